// ----- design/dot_star_pattern_matcher_top_defines.svh -----
// Assertion helpers shared by the matcher RTL
`ifndef DOT_STAR_PATTERN_MATCHER_TOP_DEFINES_SVH
`define DOT_STAR_PATTERN_MATCHER_TOP_DEFINES_SVH

// Condition that must hold at every clock edge out of reset
`define DSM_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Implication checked at every clock edge out of reset
`define DSM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- design/dsm_pkg.sv -----
package dsm_pkg;

	typedef enum logic [1:0] {
		FN_NEW  = 2'd0,
		FN_PAT  = 2'd1,
		FN_TEXT = 2'd2,
		FN_FIN  = 2'd3
	} func_e_t;

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_CLEAR = 3'd1,
		OP_ADD   = 3'd2,
		OP_STAR  = 3'd3,
		OP_TEXT  = 3'd4
	} op_e_t;

	localparam logic [7:0] STAR_CHAR = 8'h2A;
	localparam logic [7:0] DOT_CHAR  = 8'h2E;

	typedef struct packed {
		logic [1:0] func;
		logic [7:0] ch;
	} cmd_t;

	typedef struct packed {
		logic matched;
		logic error;
	} verdict_t;

	// broadcast to every cell
	typedef struct packed {
		op_e_t      op;
		logic [7:0] ch;
	} ctl_t;

	// left to right: position state and closure carry
	typedef struct packed {
		logic live;
		logic closed;
		logic valid;
	} fwd_t;

	// right to left: token presence and self-loop hit for the position on the left
	typedef struct packed {
		logic valid;
		logic stay;
	} bwd_t;

endpackage

// ----- design/dsm_chan_if.sv -----
interface dsm_chan_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- design/dsm_cell.sv -----
// One pattern token and the live bit of the position just past it.
module dsm_cell (
	input  logic          clk,
	input  logic          arst_n,
	input  dsm_pkg::ctl_t ctl,
	input  dsm_pkg::fwd_t from_left,
	input  dsm_pkg::bwd_t from_right,
	output dsm_pkg::fwd_t to_right,
	output dsm_pkg::bwd_t to_left
);
	import dsm_pkg::*;

	logic [7:0] char_q;
	logic       star_q;
	logic       valid_q;
	logic       live_q;
	logic       acc;
	logic       adv;
	logic       closed;
	logic       is_tail;
	logic       is_last;

	assign acc     = (char_q == DOT_CHAR) || (char_q == ctl.ch);
	assign adv     = from_left.live & acc & ~star_q & valid_q;
	assign closed  = adv | from_right.stay | (from_left.closed & star_q & valid_q);
	assign is_tail = from_left.valid & ~valid_q;
	assign is_last = valid_q & ~from_right.valid;

	assign to_left.valid  = valid_q;
	assign to_left.stay   = from_left.live & acc & star_q & valid_q;
	assign to_right.live   = live_q;
	assign to_right.closed = closed;
	assign to_right.valid  = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			live_q  <= 1'b0;
		end else begin
			unique case (ctl.op)
				OP_CLEAR: begin
					valid_q <= 1'b0;
					live_q  <= 1'b0;
				end
				OP_ADD: begin
					if (is_tail) valid_q <= 1'b1;
				end
				OP_STAR: begin
					if (is_last) live_q <= from_left.live;
				end
				OP_TEXT: begin
					live_q <= closed;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.op == OP_ADD && is_tail) begin
			char_q <= ctl.ch;
			star_q <= 1'b0;
		end else if (ctl.op == OP_STAR && is_last) begin
			star_q <= 1'b1;
		end
	end

endmodule

// ----- design/dot_star_pattern_matcher_top.sv -----
// Dot-star pattern matcher.
// cmd channel (sink): func selects new job, pattern byte, text byte or finish;
// ch carries the byte. verdict channel (source): one transfer per finish,
// carrying matched and error.
// Pattern bytes build tokens in a row of MAX_TOKENS cells; each cell holds a
// token and the live bit of the position after it. A text byte updates every
// cell at once, the star closure rippling left to right along the row.
// One item can be taken per cycle while cmd.ready is high. A finish puts
// its verdict in the output register as it is taken.
// cmd.ready drops only while a verdict is held and verdict.ready is low;
// items are then held off until the verdict transfers.
// Reset (arst_n low) leaves the block as after a new job: no tokens, no
// text, error clear. A finish right after reset reports matched = 1.
// Pattern bytes after text, or beyond MAX_TOKENS tokens, set a sticky error
// that forces matched low until the next new job.
`include "dot_star_pattern_matcher_top_defines.svh"

module dot_star_pattern_matcher_top #(
	parameter int MAX_TOKENS = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	dsm_chan_if.sink   cmd,
	dsm_chan_if.source verdict
);
	import dsm_pkg::*;

	localparam int CW = $clog2(MAX_TOKENS + 1);

	logic [CW-1:0]       count_q;
	logic                last_star_q;
	logic                text_q;
	logic                err_q;
	logic                pos0_q;
	logic                vld_q;
	verdict_t            verdict_q;
	logic                in_fire;
	func_e_t             func;
	ctl_t                ctl;
	logic                err_set;
	logic                fin;
	fwd_t                fwd [MAX_TOKENS+1];
	bwd_t                bwd [MAX_TOKENS+1];
	logic [MAX_TOKENS:0] live_vec;
	logic [MAX_TOKENS:0] live_above;

	assign cmd.ready    = ~vld_q | verdict.ready;
	assign in_fire      = cmd.valid & cmd.ready;
	assign func         = func_e_t'(cmd.data.func);
	assign verdict.valid = vld_q;
	assign verdict.data  = verdict_q;

	always_comb begin
		ctl.op  = OP_NONE;
		ctl.ch  = cmd.data.ch;
		err_set = 1'b0;
		fin     = 1'b0;
		if (in_fire) begin
			unique case (func)
				FN_NEW: ctl.op = OP_CLEAR;
				FN_PAT: begin
					priority if (text_q) begin
						err_set = 1'b1;
					end else if (cmd.data.ch == STAR_CHAR && count_q != '0 && !last_star_q) begin
						ctl.op = OP_STAR;
					end else if (count_q == CW'(MAX_TOKENS)) begin
						err_set = 1'b1;
					end else begin
						ctl.op = OP_ADD;
					end
				end
				FN_TEXT: ctl.op = OP_TEXT;
				FN_FIN:  fin = 1'b1;
			endcase
		end
	end

	assign fwd[0].live   = pos0_q;
	assign fwd[0].closed = bwd[0].stay;
	assign fwd[0].valid  = 1'b1;
	assign bwd[MAX_TOKENS] = '0;
	assign live_vec[0]   = pos0_q;

	for (genvar k = 0; k < MAX_TOKENS; k++) begin : g_cell
		dsm_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.from_left  (fwd[k]),
			.from_right (bwd[k+1]),
			.to_right   (fwd[k+1]),
			.to_left    (bwd[k])
		);
		assign live_vec[k+1] = fwd[k+1].live;
	end

	assign live_above = live_vec >> count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			last_star_q <= 1'b0;
			text_q      <= 1'b0;
			err_q       <= 1'b0;
			pos0_q      <= 1'b1;
			vld_q       <= 1'b0;
		end else begin
			if (err_set) err_q <= 1'b1;
			unique case (ctl.op)
				OP_CLEAR: begin
					count_q     <= '0;
					last_star_q <= 1'b0;
					text_q      <= 1'b0;
					err_q       <= 1'b0;
					pos0_q      <= 1'b1;
				end
				OP_ADD: begin
					count_q     <= count_q + CW'(1);
					last_star_q <= 1'b0;
				end
				OP_STAR: last_star_q <= 1'b1;
				OP_TEXT: begin
					text_q <= 1'b1;
					pos0_q <= bwd[0].stay;
				end
				default: begin
				end
			endcase
			if (fin) vld_q <= 1'b1;
			else if (verdict.ready) vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			verdict_q.matched <= live_vec[count_q] & ~err_q;
			verdict_q.error   <= err_q;
		end
	end

	`DSM_ASSERT(a_count_range, count_q <= CW'(MAX_TOKENS), "token count out of range")
	`DSM_ASSERT(a_no_live_past_tail, live_above[MAX_TOKENS:1] == '0, "live bit past last token")
	`DSM_ASSERT_IMP(a_new_job_clears, in_fire && func == FN_NEW,
		##1 (count_q == '0 && !err_q && !text_q && pos0_q), "new job did not clear state")
	`DSM_ASSERT_IMP(a_err_sticky, $fell(err_q), $past(in_fire && func == FN_NEW),
		"error cleared without new job")

endmodule

// ----- test/dot_star_pattern_matcher_top_tb.sv -----
module dot_star_pattern_matcher_top_tb;
	import dsm_pkg::*;

	localparam int MAX_TOKENS = 32;
	localparam int ITEM_TARGET = 1350;
	localparam int STALL_LIMIT = 2000;
	localparam int IDLE_PCT = 33;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	dsm_chan_if #(.payload_t(cmd_t)) cmd_ch ();
	dsm_chan_if #(.payload_t(verdict_t)) verdict_ch ();

	dot_star_pattern_matcher_top #(.MAX_TOKENS(MAX_TOKENS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.verdict(verdict_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// matcher state as predicted
	logic [7:0] token_char [MAX_TOKENS];
	bit token_star [MAX_TOKENS];
	int token_total = 0;
	logic [MAX_TOKENS:0] live_set = '0;
	bit text_seen = 1'b0;
	bit sticky_err = 1'b0;

	verdict_t expected_verdicts [$];

	int fail_count = 0;
	int items_sent = 0;
	int jobs_run = 0;
	int verdicts_checked = 0;
	int matches_seen = 0;
	int errors_seen = 0;
	int stall_cycles = 0;
	bit no_idle = 1'b0;

	function automatic logic [MAX_TOKENS:0] close_over_stars(logic [MAX_TOKENS:0] s);
		for (int k = 0; k < token_total; k++)
			if (s[k] && token_star[k])
				s[k + 1] = 1'b1;
		return s;
	endfunction

	task automatic predict_item(cmd_t c);
		logic [MAX_TOKENS:0] nxt;
		logic [MAX_TOKENS:0] cur;
		verdict_t v;
		case (func_e_t'(c.func))
			FN_NEW: begin
				token_total = 0;
				live_set = '0;
				text_seen = 1'b0;
				sticky_err = 1'b0;
			end
			FN_PAT: begin
				if (text_seen) begin
					sticky_err = 1'b1;
				end else if (c.ch == STAR_CHAR && token_total > 0 &&
						!token_star[token_total - 1]) begin
					token_star[token_total - 1] = 1'b1;
				end else if (token_total >= MAX_TOKENS) begin
					sticky_err = 1'b1;
				end else begin
					token_char[token_total] = c.ch;
					token_star[token_total] = 1'b0;
					token_total++;
				end
			end
			FN_TEXT: begin
				if (!text_seen) begin
					live_set = close_over_stars({{MAX_TOKENS{1'b0}}, 1'b1});
					text_seen = 1'b1;
				end
				nxt = '0;
				for (int k = 0; k < token_total; k++) begin
					if (live_set[k] && (token_char[k] == DOT_CHAR || token_char[k] == c.ch)) begin
						if (token_star[k])
							nxt[k] = 1'b1;
						else
							nxt[k + 1] = 1'b1;
					end
				end
				live_set = close_over_stars(nxt);
			end
			FN_FIN: begin
				cur = text_seen ? live_set : close_over_stars({{MAX_TOKENS{1'b0}}, 1'b1});
				v.matched = cur[token_total] && !sticky_err;
				v.error = sticky_err;
				expected_verdicts.push_back(v);
			end
		endcase
	endtask

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic send_item(func_e_t f, logic [7:0] c);
		cmd_t item;
		item.func = f;
		item.ch = c;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
			cmd_ch.valid = 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid = 1'b1;
		cmd_ch.data = item;
		do
			@(posedge clk);
		while (!cmd_ch.ready);
		predict_item(item);
		items_sent++;
		@(negedge clk);
		cmd_ch.valid = 1'b0;
	endtask

	always @(negedge clk)
		verdict_ch.ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);

	always @(posedge clk) begin
		verdict_t want;
		if (verdict_ch.valid && verdict_ch.ready) begin
			if (expected_verdicts.size() == 0) begin
				$display("%0t: verdict transfer with none expected, actual %b/%b", $time,
					verdict_ch.data.matched, verdict_ch.data.error);
				fail_count++;
			end else begin
				want = expected_verdicts.pop_front();
				verdicts_checked++;
				if (verdict_ch.data.matched) matches_seen++;
				if (verdict_ch.data.error) errors_seen++;
				if (verdict_ch.data.matched !== want.matched) begin
					$display("%0t: matched mismatch, expected %b actual %b", $time,
						want.matched, verdict_ch.data.matched);
					fail_count++;
				end
				if (verdict_ch.data.error !== want.error) begin
					$display("%0t: error mismatch, expected %b actual %b", $time,
						want.error, verdict_ch.data.error);
					fail_count++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (verdict_ch.valid && verdict_ch.ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
				$display("** dot_star_pattern_matcher_top: FAILED **");
				$finish;
			end
		end
	end

	task automatic test_finish_after_reset();
		send_item(FN_FIN, 8'h00);
	endtask

	// star on empty pattern and after a starred token is a literal
	task automatic test_star_grouping();
		send_item(FN_NEW, 8'hFF);
		send_item(FN_PAT, STAR_CHAR);
		send_item(FN_PAT, STAR_CHAR);
		send_item(FN_PAT, STAR_CHAR);
		send_item(FN_TEXT, STAR_CHAR);
		send_item(FN_TEXT, STAR_CHAR);
		send_item(FN_FIN, 8'hFF);
	endtask

	// dot, byte extremes, repeated finish with more text in between
	task automatic test_dot_and_refinish();
		send_item(FN_NEW, 8'h00);
		send_item(FN_PAT, 8'h00);
		send_item(FN_PAT, DOT_CHAR);
		send_item(FN_PAT, 8'hFF);
		send_item(FN_PAT, STAR_CHAR);
		send_item(FN_TEXT, 8'h00);
		send_item(FN_TEXT, 8'hA5);
		send_item(FN_FIN, 8'h00);
		send_item(FN_TEXT, 8'hFF);
		send_item(FN_FIN, 8'hFF);
		send_item(FN_FIN, 8'h55);
	endtask

	task automatic test_pattern_after_text();
		send_item(FN_NEW, 8'h00);
		send_item(FN_PAT, 8'h61);
		send_item(FN_TEXT, 8'h61);
		send_item(FN_PAT, 8'h62);
		send_item(FN_FIN, 8'h00);
	endtask

	function automatic logic [7:0] pick_token_char();
		int r;
		r = $urandom_range(9);
		if (r < 3) return DOT_CHAR;
		if (r == 3) return STAR_CHAR;
		if (r == 4) return 8'($urandom_range(255));
		return 8'h61 + 8'($urandom_range(2));
	endfunction

	// one job: pattern from random tokens, text mostly built to match
	task automatic run_job(int min_tok, int max_tok);
		logic [7:0] tch [$];
		bit tst [$];
		logic [7:0] txt [$];
		int n;
		int reps;
		int pos;
		n = $urandom_range(max_tok, min_tok);
		for (int i = 0; i < n; i++) begin
			tch.push_back(pick_token_char());
			tst.push_back($urandom_range(2) == 0);
		end
		for (int i = 0; i < n; i++) begin
			reps = tst[i] ? $urandom_range(3) : 1;
			for (int j = 0; j < reps; j++)
				txt.push_back(tch[i] == DOT_CHAR ? 8'($urandom_range(255)) : tch[i]);
		end
		if ($urandom_range(4) == 0) begin
			case ($urandom_range(2))
				0: if (txt.size() > 0) begin
					pos = $urandom_range(txt.size() - 1);
					txt[pos] = 8'($urandom_range(255));
				end
				1: if (txt.size() > 0) void'(txt.pop_back());
				default: txt.push_back(8'($urandom_range(255)));
			endcase
		end
		jobs_run++;
		send_item(FN_NEW, 8'($urandom_range(255)));
		for (int i = 0; i < n; i++) begin
			send_item(FN_PAT, tch[i]);
			if (tst[i])
				send_item(FN_PAT, STAR_CHAR);
		end
		foreach (txt[i])
			send_item(FN_TEXT, txt[i]);
		if ($urandom_range(9) == 0)
			send_item(FN_PAT, 8'($urandom_range(255)));
		send_item(FN_FIN, 8'($urandom_range(255)));
		if ($urandom_range(4) == 0) begin
			reps = $urandom_range(3);
			for (int j = 0; j < reps; j++)
				send_item(FN_TEXT, $urandom_range(1) ? 8'($urandom_range(255)) : 8'h61);
			send_item(FN_FIN, 8'($urandom_range(255)));
		end
	endtask

	task automatic test_overflow();
		for (int i = 0; i < 4; i++)
			run_job(MAX_TOKENS - 2, MAX_TOKENS + 8);
	endtask

	task automatic test_random_jobs();
		int start_items;
		start_items = items_sent;
		while (items_sent < ITEM_TARGET) begin
			no_idle = (items_sent - start_items > 400) && (items_sent - start_items < 700);
			if ($urandom_range(99) < 8)
				send_item(func_e_t'($urandom_range(3)), 8'($urandom_range(255)));
			else if ($urandom_range(29) == 0)
				run_job(MAX_TOKENS - 2, MAX_TOKENS + 8);
			else
				run_job(0, 8);
		end
		no_idle = 1'b0;
	endtask

	initial begin
		cmd_ch.valid = 1'b0;
		cmd_ch.data = '0;
		verdict_ch.ready = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_finish_after_reset();
		test_star_grouping();
		test_dot_and_refinish();
		test_pattern_after_text();
		test_overflow();
		test_random_jobs();

		while (expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);

		$display("Sent %0d items over %0d jobs, including overflow and misordered pattern bytes.",
			items_sent, jobs_run);
		$display("Checked %0d verdicts: %0d matched, %0d flagged error.",
			verdicts_checked, matches_seen, errors_seen);
		if (fail_count == 0)
			$display("** dot_star_pattern_matcher_top: PASSED **");
		else
			$display("** dot_star_pattern_matcher_top: FAILED **");
		$finish;
	end

endmodule

// ----- files.f -----
+incdir+design
design/dsm_pkg.sv
design/dsm_chan_if.sv
design/dsm_cell.sv
design/dot_star_pattern_matcher_top.sv
test/dot_star_pattern_matcher_top_tb.sv
